[rtl/core/sld_pkg.sv]
// Shared types and constants for the string literal decoder.
// No dependencies; the front, queue, back and top modules import this package.
package sld_pkg;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_STR   = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_ESC1  = 3'd3,
    MODE_ESC2  = 3'd4,
    MODE_AFTER = 3'd5
  } scan_mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_UNTERM = 2'd2,
    KIND_NOTSTR = 2'd3
  } item_kind_t;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  // Most results one text word can give
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // One result word
  typedef struct packed {
    logic [7:0] char_out;
    item_kind_t item_kind;
    logic       byte_used;
  } result_t;

  // All results of one text word, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]                count;
    result_t [MAX_RESULTS-1:0]       slot;
  } bundle_t;

endpackage

[rtl/core/sld_in_if.sv]
// Text input channel: one text byte or an end-of-text mark per word.
// No dependencies.
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

[rtl/core/sld_out_if.sv]
// Result channel: one decoded character or string event per word.
// No dependencies.
interface sld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] item_kind;
  logic       byte_used;
  logic       last;

  modport source (output valid, char_out, item_kind, byte_used, last, input ready);
  modport sink (input valid, char_out, item_kind, byte_used, last, output ready);
endinterface

[rtl/core/sld_front.sv]
// Front end: accepts text words, runs the scanner and builds result bundles.
// Depends on sld_pkg and sld_in_if.
module sld_front (
  input  logic              clk,
  input  logic              rst,
  sld_in_if.sink            text_in,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              q_full,
  output logic              push,
  output sld_pkg::bundle_t  push_data
);
  import sld_pkg::*;

  typedef struct packed {
    logic       hit;
    result_t    res;
    scan_mode_t mode;
  } body_t;

  scan_mode_t mode, mode_next;
  logic [3:0] digit_one, digit_one_next;
  logic [3:0] digit_two, digit_two_next;
  logic       concat_mode;
  logic       accept;
  logic       eot;
  logic [7:0] b;
  logic       is_digit;
  logic [9:0] esc_value;
  body_t      body;
  bundle_t    bnd;
  result_t    held_one_res, held_two_res;

  // Handle a byte (or end of text) as inside the string body
  function automatic body_t body_byte(input logic [7:0] bb, input logic et,
                                      input logic cm);
    body_t r;
    r = '0;
    r.res.item_kind = KIND_CHAR;
    if (et || bb == CH_NUL || bb == CH_NL) begin
      r.hit = 1'b1;
      r.res.item_kind = KIND_UNTERM;
      r.mode = MODE_IDLE;
    end else if (bb == CH_BSLASH) begin
      r.mode = MODE_ESC;
    end else if (bb == CH_QUOTE) begin
      if (cm) begin
        r.mode = MODE_AFTER;
      end else begin
        r.hit = 1'b1;
        r.res.item_kind = KIND_CLOSED;
        r.res.byte_used = 1'b1;
        r.mode = MODE_IDLE;
      end
    end else begin
      r.hit = 1'b1;
      r.res.char_out = bb;
      r.mode = MODE_STR;
    end
    return r;
  endfunction

  assign text_in.ready = !q_full;
  assign accept = text_in.valid && text_in.ready;
  assign eot = text_in.end_of_text;
  assign b = text_in.text_byte;
  assign is_digit = !eot && b >= CH_ZERO && b <= CH_NINE;
  assign esc_value = 10'(digit_one) * 10'd100 + 10'(digit_two) * 10'd10 + 10'(b[3:0]);
  assign body = body_byte(b, eot, concat_mode);

  // Held digits emitted back as plain text
  always_comb begin
    held_one_res = '0;
    held_one_res.item_kind = KIND_CHAR;
    held_one_res.char_out = CH_ZERO + {4'b0, digit_one};
    held_two_res = held_one_res;
    held_two_res.char_out = CH_ZERO + {4'b0, digit_two};
  end

  // Next scanner state and the bundle of results
  always_comb begin
    mode_next = mode;
    digit_one_next = digit_one;
    digit_two_next = digit_two;
    bnd = '0;
    case (mode)
      MODE_STR: begin
        mode_next = body.mode;
        if (body.hit) begin
          bnd.slot[0] = body.res;
          bnd.count = CNT_W'(1);
        end
      end
      MODE_ESC: begin
        if (eot) begin
          mode_next = MODE_IDLE;
          bnd.slot[0].item_kind = KIND_UNTERM;
          bnd.count = CNT_W'(1);
        end else if (is_digit) begin
          digit_one_next = b[3:0];
          mode_next = MODE_ESC1;
        end else begin
          mode_next = MODE_STR;
          bnd.slot[0].item_kind = KIND_CHAR;
          if (b == CH_N) begin
            bnd.slot[0].char_out = CH_NL;
          end else if (b == CH_T) begin
            bnd.slot[0].char_out = CH_TAB;
          end else begin
            bnd.slot[0].char_out = b;
          end
          bnd.count = CNT_W'(1);
        end
      end
      MODE_ESC1: begin
        if (is_digit) begin
          digit_two_next = b[3:0];
          mode_next = MODE_ESC2;
        end else begin
          mode_next = body.mode;
          bnd.slot[0] = held_one_res;
          bnd.slot[1] = body.res;
          bnd.count = body.hit ? CNT_W'(2) : CNT_W'(1);
        end
      end
      MODE_ESC2: begin
        if (is_digit) begin
          mode_next = MODE_STR;
          bnd.slot[0].item_kind = KIND_CHAR;
          bnd.slot[0].char_out = esc_value[7:0];
          bnd.count = CNT_W'(1);
        end else begin
          mode_next = body.mode;
          bnd.slot[0] = held_one_res;
          bnd.slot[1] = held_two_res;
          bnd.slot[2] = body.res;
          bnd.count = body.hit ? CNT_W'(3) : CNT_W'(2);
        end
      end
      MODE_AFTER: begin
        if (!eot && b == CH_SPACE) begin
          mode_next = MODE_AFTER;
        end else if (!eot && b == CH_QUOTE) begin
          mode_next = MODE_STR;
        end else begin
          mode_next = MODE_IDLE;
          bnd.slot[0].item_kind = KIND_CLOSED;
          bnd.count = CNT_W'(1);
        end
      end
      default: begin
        if (!eot && b == CH_QUOTE) begin
          mode_next = MODE_STR;
        end else begin
          mode_next = MODE_IDLE;
          bnd.slot[0].item_kind = KIND_NOTSTR;
          bnd.count = CNT_W'(1);
        end
      end
    endcase
  end

  assign push = accept && (bnd.count != '0);
  assign push_data = bnd;

  // Advance scanner state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      digit_one <= '0;
      digit_two <= '0;
    end else if (accept) begin
      mode <= mode_next;
      digit_one <= digit_one_next;
      digit_two <= digit_two_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      concat_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      concat_mode <= cfg_wr_data;
    end
  end

endmodule

[rtl/core/sld_queue.sv]
// Short queue of result bundles between the front and back ends.
// Depends on sld_pkg.
module sld_queue #(
  parameter int DEPTH = sld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sld_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output sld_pkg::bundle_t  pop_data
);
  import sld_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  bundle_t             mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [FILL_W-1:0]   fill;

  assign full = (fill == FILL_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data = mem[rd_ptr];

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/core/sld_back.sv]
// Back end: unpacks bundles into single result words behind an output register.
// Depends on sld_pkg and sld_out_if.
module sld_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  sld_pkg::bundle_t  q_data,
  output logic              pop,
  sld_out_if.source         result_out
);
  import sld_pkg::*;

  bundle_t           cur;
  logic              cur_valid;
  logic [CNT_W-1:0]  idx;
  logic              advance;
  logic              is_final;
  logic              cur_done;
  result_t           res;
  logic              out_valid;
  result_t           out_res;
  logic              out_last;

  assign advance = cur_valid && (!out_valid || result_out.ready);
  assign is_final = (idx == cur.count - CNT_W'(1));
  assign cur_done = advance && is_final;
  assign pop = q_not_empty && (!cur_valid || cur_done);
  assign res = cur.slot[idx[$clog2(MAX_RESULTS)-1:0]];

  // Hold the bundle being unpacked
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx <= '0;
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end else if (advance) begin
      idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
      out_last <= is_final;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.char_out = out_res.char_out;
  assign result_out.item_kind = out_res.item_kind;
  assign result_out.byte_used = out_res.byte_used;
  assign result_out.last = out_last;

endmodule

[rtl/core/string_literal_decoder.sv]
// Top level of the string literal decoder: front end, bundle queue, back end.
// Depends on sld_pkg, sld_in_if, sld_out_if, sld_front, sld_queue, sld_back.
//
//   Channel      Dir   Word
//   text_in      in    text_byte[7:0], end_of_text
//   result_out   out   char_out[7:0], item_kind[1:0], byte_used, last
//   cfg_wr_*     in    concat_mode (single bit, no read-back)
//
// One text word is taken per cycle while the queue has room; each word yields
// zero to three results; the back end sends one result per cycle while
// result_out is ready, so words flow at one per cycle while each gives at
// most one result; a word with more results holds the back end until all are
// sent. A result goes through the queue, bundle and output registers.
// Synchronous reset clears scanner, concat_mode, queue, bundle valid and output valid.
// A stalled output fills the queue, then drops text_in.ready.
module string_literal_decoder #(
  parameter int QUEUE_DEPTH = sld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sld_in_if.sink     text_in,
  sld_out_if.source  result_out,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import sld_pkg::*;

  logic    push, pop, q_full, q_not_empty;
  bundle_t push_data, pop_data;

  // Scanner
  sld_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  // Bundle queue
  sld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  // Result serializer
  sld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .result_out  (result_out)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for string_literal_decoder: random and directed text words go in, and every
// result word is checked against a cycle-free decoder kept alongside.
// Depends on sld_pkg, sld_in_if, sld_out_if and the string_literal_decoder RTL.
module testbench;
  import sld_pkg::*;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_word_t;

  typedef struct packed {
    logic [7:0] ch;
    item_kind_t kind;
    logic       used;
    logic       last;
  } decoded_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  sld_in_if  text_in_if ();
  sld_out_if result_if ();

  string_literal_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_in_if),
    .result_out  (result_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Words waiting to be offered, and decoded results still owed by the block
  text_word_t text_words[$];
  decoded_t   decoded_due[$];
  decoded_t   word_results[$];

  // Decoder state shadowed by the testbench
  scan_mode_t scan_state;
  logic [3:0] digit_hi;
  logic [3:0] digit_mid;
  logic       concat_on;

  int   words_taken = 0;
  int   errors = 0;
  bit   idle_on = 1'b1;
  logic rx_hold = 1'b0;
  int   gap_left;
  int   stall_left;

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow
  // ---------------------------------------------------------------------------

  function automatic void emit(logic [7:0] ch, item_kind_t kind, logic used);
    decoded_t d;
    d.ch   = ch;
    d.kind = kind;
    d.used = used;
    d.last = 1'b0;
    word_results.push_back(d);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Handle a byte (or the end of text) as part of the string body
  function automatic void scan_body(logic [7:0] b, logic eot);
    if (eot || b == CH_NUL || b == CH_NL) begin
      scan_state = MODE_IDLE;
      emit('0, KIND_UNTERM, 1'b0);
    end else if (b == CH_BSLASH) begin
      scan_state = MODE_ESC;
    end else if (b == CH_QUOTE) begin
      if (concat_on) begin
        scan_state = MODE_AFTER;
      end else begin
        scan_state = MODE_IDLE;
        emit('0, KIND_CLOSED, 1'b1);
      end
    end else begin
      scan_state = MODE_STR;
      emit(b, KIND_CHAR, 1'b0);
    end
  endfunction

  // Decode one accepted text word and queue the results it owes
  function automatic void decode_text_word(logic [7:0] b, logic eot);
    logic [7:0] digit;
    logic [7:0] ch;
    int         code;
    decoded_t   d;
    word_results.delete();
    digit = b - CH_ZERO;
    case (scan_state)
      MODE_STR: scan_body(b, eot);
      MODE_ESC: begin
        if (eot) begin
          scan_state = MODE_IDLE;
          emit('0, KIND_UNTERM, 1'b0);
        end else if (is_digit(b)) begin
          digit_hi   = digit[3:0];
          scan_state = MODE_ESC1;
        end else begin
          ch = b;
          if (b == CH_N) ch = CH_NL;
          else if (b == CH_T) ch = CH_TAB;
          scan_state = MODE_STR;
          emit(ch, KIND_CHAR, 1'b0);
        end
      end
      MODE_ESC1: begin
        if (!eot && is_digit(b)) begin
          digit_mid  = digit[3:0];
          scan_state = MODE_ESC2;
        end else begin
          emit(CH_ZERO + digit_hi, KIND_CHAR, 1'b0);
          scan_body(b, eot);
        end
      end
      MODE_ESC2: begin
        if (!eot && is_digit(b)) begin
          code       = 100 * digit_hi + 10 * digit_mid + digit[3:0];
          scan_state = MODE_STR;
          emit(code[7:0], KIND_CHAR, 1'b0);
        end else begin
          emit(CH_ZERO + digit_hi, KIND_CHAR, 1'b0);
          emit(CH_ZERO + digit_mid, KIND_CHAR, 1'b0);
          scan_body(b, eot);
        end
      end
      MODE_AFTER: begin
        if (!eot && b == CH_SPACE) begin
          // skip the space
        end else if (!eot && b == CH_QUOTE) begin
          scan_state = MODE_STR;
        end else begin
          scan_state = MODE_IDLE;
          emit('0, KIND_CLOSED, 1'b0);
        end
      end
      default: begin
        if (!eot && b == CH_QUOTE) begin
          scan_state = MODE_STR;
        end else begin
          scan_state = MODE_IDLE;
          emit('0, KIND_NOTSTR, 1'b0);
        end
      end
    endcase
    // Flag the final result of this word
    foreach (word_results[i]) begin
      d      = word_results[i];
      d.last = (i == word_results.size() - 1);
      decoded_due.push_back(d);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_word(logic [7:0] b, logic eot);
    text_word_t w;
    w.text_byte   = b;
    w.end_of_text = eot;
    text_words.push_back(w);
  endfunction

  // Append one quoted literal with random body and random ending
  task automatic add_literal(bit joined);
    int         len;
    int         k;
    int         n;
    logic [7:0] b;
    push_word(CH_QUOTE, 1'b0);
    len = $urandom_range(0, 8);
    repeat (len) begin
      k = $urandom_range(0, 9);
      case (k)
        0, 1, 2, 3: begin
          b = 8'($urandom_range(8'h20, 8'h7E));
          if (b == CH_QUOTE || b == CH_BSLASH) b = CH_SPACE;
          push_word(b, 1'b0);
        end
        4: begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_QUOTE || b == CH_BSLASH || b == CH_NL) b = 8'hA5;
          push_word(b, 1'b0);
        end
        5: begin
          push_word(CH_BSLASH, 1'b0);
          push_word(8'($urandom_range(0, 255)), 1'b0);
        end
        6: begin
          push_word(CH_BSLASH, 1'b0);
          push_word($urandom_range(0, 1) ? CH_N : CH_T, 1'b0);
        end
        default: begin
          // digit escape: full three digits, or one to three digits
          n = (k == 7) ? 3 : $urandom_range(1, 3);
          push_word(CH_BSLASH, 1'b0);
          repeat (n) push_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
      endcase
    end
    // End the literal: closed, unterminated, or left open
    k = $urandom_range(0, 11);
    if (k < 7) begin
      push_word(CH_QUOTE, 1'b0);
      if (joined) begin
        repeat ($urandom_range(0, 3)) push_word(CH_SPACE, 1'b0);
        case ($urandom_range(0, 3))
          0: add_literal(joined);
          1: push_word(CH_TAB, 1'b0);
          2: push_word(8'($urandom_range(0, 255)), 1'b0);
          default: push_word(8'($urandom_range(0, 255)), 1'b1);
        endcase
      end
    end else if (k == 7) begin
      push_word(CH_NL, 1'b0);
    end else if (k == 8) begin
      push_word(CH_NUL, 1'b0);
    end else if (k == 9) begin
      push_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Mostly literals, some stray bytes and end marks between them
  task automatic fill_random(int count, bit joined);
    int goal;
    int k;
    goal = text_words.size() + count;
    while (text_words.size() < goal) begin
      k = $urandom_range(0, 9);
      if (k == 0) push_word(8'($urandom_range(0, 255)), 1'b0);
      else if (k == 1) push_word(8'($urandom_range(0, 255)), 1'b1);
      else add_literal(joined);
    end
  endtask

  task automatic write_concat(logic value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    concat_on    = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Wait until every word is taken and every result seen, then let the pipe settle
  task automatic wait_drained();
    while (text_words.size() != 0 || text_in_if.valid || decoded_due.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Text word driver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_text
    text_word_t w;
    if (rst) begin
      text_in_if.valid <= 1'b0;
      gap_left         <= 0;
    end else begin
      if (text_in_if.valid && text_in_if.ready) begin
        decode_text_word(text_in_if.text_byte, text_in_if.end_of_text);
        words_taken++;
      end
      if (text_in_if.valid && !text_in_if.ready) begin
        // hold the offered word
      end else if (gap_left > 0) begin
        gap_left         <= gap_left - 1;
        text_in_if.valid <= 1'b0;
      end else if (text_words.size() > 0 && idle_on && $urandom_range(0, 5) == 0) begin
        gap_left         <= $urandom_range(0, 6);
        text_in_if.valid <= 1'b0;
      end else if (text_words.size() > 0) begin
        w = text_words.pop_front();
        text_in_if.valid       <= 1'b1;
        text_in_if.text_byte   <= w.text_byte;
        text_in_if.end_of_text <= w.end_of_text;
      end else begin
        text_in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
    end else if (rx_hold) begin
      result_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      result_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left      <= $urandom_range(0, 6);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    decoded_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (decoded_due.size() == 0) begin
        $error("unexpected result word: char_out %0h item_kind %0d byte_used %0b last %0b",
               result_if.char_out, result_if.item_kind, result_if.byte_used, result_if.last);
        errors++;
      end else begin
        want = decoded_due.pop_front();
        if (result_if.char_out !== want.ch) begin
          $error("char_out: expected %0h, got %0h", want.ch, result_if.char_out);
          errors++;
        end
        if (result_if.item_kind !== want.kind) begin
          $error("item_kind: expected %0d, got %0d", want.kind, result_if.item_kind);
          errors++;
        end
        if (result_if.byte_used !== want.used) begin
          $error("byte_used: expected %0b, got %0b", want.used, result_if.byte_used);
          errors++;
        end
        if (result_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_if.last);
          errors++;
        end
      end
    end
  end

  // Long output hold-off so the block fills up and drops its input ready
  initial begin
    wait (words_taken >= 60);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------

  initial begin
    clk                    = 1'b0;
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = 1'b0;
    text_in_if.valid       = 1'b0;
    text_in_if.text_byte   = '0;
    text_in_if.end_of_text = 1'b0;
    result_if.ready        = 1'b0;
    concat_on              = 1'b0;
    scan_state             = MODE_IDLE;
    digit_hi               = '0;
    digit_mid              = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, single strings
    write_concat(1'b0);
    push_word("a", 1'b0);                    // stray byte: not a string
    push_word(CH_QUOTE, 1'b1);               // end mark while idle, byte ignored
    push_word(CH_QUOTE, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(CH_BSLASH, 1'b0);
    push_word(CH_T, 1'b0);
    push_word(CH_BSLASH, 1'b0);              // full digit escape wrapping past 255
    push_word("9", 1'b0);
    push_word("9", 1'b0);
    push_word("9", 1'b0);
    push_word(CH_BSLASH, 1'b0);              // two digits, then the closing quote
    push_word("4", 1'b0);
    push_word("5", 1'b0);
    push_word(CH_QUOTE, 1'b0);
    push_word(CH_QUOTE, 1'b0);               // escaped newline, then NUL ends it unterminated
    push_word(CH_BSLASH, 1'b0);
    push_word(CH_NL, 1'b0);
    push_word(CH_NUL, 1'b0);
    push_word(CH_QUOTE, 1'b0);               // backslash then end of text
    push_word(CH_BSLASH, 1'b0);
    push_word(CH_BSLASH, 1'b1);
    push_word(CH_QUOTE, 1'b0);               // one digit then end of text
    push_word(CH_BSLASH, 1'b0);
    push_word("3", 1'b0);
    push_word("5", 1'b1);
    wait_drained();

    // Directed joining, then random with joining on
    write_concat(1'b1);
    push_word(CH_QUOTE, 1'b0);
    push_word("x", 1'b0);
    push_word(CH_QUOTE, 1'b0);
    push_word(CH_SPACE, 1'b0);
    push_word(CH_QUOTE, 1'b0);
    push_word(CH_QUOTE, 1'b0);
    push_word(CH_TAB, 1'b0);                 // tab after close ends the string
    fill_random(100, 1'b1);
    wait_drained();

    // Random, joining off
    write_concat(1'b0);
    fill_random(100, 1'b0);
    wait_drained();

    // Random, joining on, no idling on either side
    idle_on = 1'b0;
    write_concat(1'b1);
    fill_random(100, 1'b1);
    wait_drained();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
